[sv/bol_pkg.sv]
package bol_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int MODE_W = 4;
	localparam int POS_W  = 4;
	localparam int STAT_W = 3;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	// wide enough for a cell index, a count and a requested position
	localparam int SEL_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_DATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT  = 4'd0,
		MODE_INS_BACK   = 4'd1,
		MODE_INS_UNIQUE = 4'd2,
		MODE_POP_FRONT  = 4'd3,
		MODE_REMOVE     = 4'd4,
		MODE_READ_INDEX = 4'd5,
		MODE_READ_FRONT = 4'd6,
		MODE_READ_BACK  = 4'd7,
		MODE_CLEAR      = 4'd8
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_RANGE    = 3'd2,
		ST_DUP      = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] value;
		logic              search;
		logic              shift_l;
		logic              shift_r;
		logic              load_back;
		logic              rd_en;
		logic [SEL_W-1:0]  sel;
	} cell_cmd_t;

endpackage

[sv/bol_cell.sv]
module bol_cell (
	input  logic                      clk,
	input  logic [bol_pkg::SEL_W-1:0]  idx,
	input  bol_pkg::cell_cmd_t         cmd,
	input  logic [bol_pkg::DATA_W-1:0] left_data,
	input  logic [bol_pkg::DATA_W-1:0] right_data,
	input  logic                      hit_in,
	output logic                      hit_out,
	input  logic [bol_pkg::DATA_W-1:0] rd_in,
	output logic [bol_pkg::DATA_W-1:0] rd_out,
	output logic [bol_pkg::DATA_W-1:0] data
);
	import bol_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic              valid;
	logic              match;
	logic              hit;

	assign valid   = idx < SEL_W'(cmd.count);
	assign match   = cmd.search && valid && (data_q == cmd.value);
	assign hit     = hit_in || match;
	assign hit_out = hit;
	assign data    = data_q;
	assign rd_out  = rd_in | ((cmd.rd_en && (idx == cmd.sel)) ? data_q : '0);

	always_ff @(posedge clk) begin
		if (cmd.shift_r) begin
			data_q <= left_data;
		end else if (cmd.shift_l && hit) begin
			data_q <= right_data;
		end else if (cmd.load_back && (idx == SEL_W'(cmd.count))) begin
			data_q <= cmd.value;
		end
	end

endmodule

[sv/bounded_ordered_list_core.sv]
// an accepted input beat's result beat is registered and shown in the next cycle
// throughput: one item per cycle while m_tready is high; every operation is done by the
//   cell chain combinationally, the match and read paths ripple through all cells of the chain
// reset (arst_n low): entry count cleared, output register emptied; cell contents stay
//   undefined until written and are never read beyond the count
module bounded_ordered_list_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] value, [35:32] position, [39:36] zero
	input  logic [bol_pkg::IN_DATA_W-1:0]  s_tdata,
	// [3:0] mode
	input  logic [bol_pkg::MODE_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] read_data, [36:32] entry_count, [39:37] zero
	output logic [bol_pkg::OUT_DATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [bol_pkg::STAT_W-1:0]     m_tuser
);
	import bol_pkg::*;

	logic                accept;
	mode_t               mode;
	logic [DATA_W-1:0]   value;
	logic [POS_W-1:0]    position;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	logic                empty;
	logic                full;

	// output register
	logic                out_valid_q;
	status_t             status_q;
	logic [DATA_W-1:0]   rdata_q;
	logic [CNT_W-1:0]    ocount_q;

	status_t             status;
	cell_cmd_t           cmd;

	// chain wiring: cell i reads neighbors i-1 and i+1
	logic [DATA_W-1:0]   cell_data [DEPTH];
	logic [DEPTH:0]      hit_chain;
	logic [DATA_W-1:0]   rd_chain  [DEPTH+1];
	logic                found;
	logic                pop_all;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;

	assign mode     = mode_t'(s_tuser);
	assign value    = s_tdata[DATA_W-1:0];
	assign position = s_tdata[DATA_W +: POS_W];

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign found = hit_chain[DEPTH];

	// a front pop seeds the hit chain so every cell shifts
	assign hit_chain[0] = pop_all;

	// decode the beat into a chain command and a status
	always_comb begin
		cmd           = '0;
		cmd.count     = count_q;
		cmd.value     = value;
		status        = ST_OK;
		count_nxt     = count_q;
		pop_all       = 1'b0;
		unique case (mode)
			MODE_INS_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					cmd.shift_r = accept;
					count_nxt   = count_q + 1'b1;
				end
			end
			MODE_INS_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					cmd.load_back = accept;
					count_nxt     = count_q + 1'b1;
				end
			end
			MODE_INS_UNIQUE: begin
				// duplicate check wins over the full check
				cmd.search = 1'b1;
				if (found) begin
					status = ST_DUP;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cmd.load_back = accept;
					count_nxt     = count_q + 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					// every cell takes its right neighbor
					pop_all      = 1'b1;
					cmd.shift_l  = accept;
					cmd.rd_en    = 1'b1;
					cmd.sel      = '0;
					count_nxt    = count_q - 1'b1;
				end
			end
			MODE_REMOVE: begin
				cmd.search = 1'b1;
				if (empty) begin
					status = ST_EMPTY;
				end else if (!found) begin
					status = ST_NOTFOUND;
				end else begin
					// cells from the first match on close the gap
					cmd.shift_l = accept;
					count_nxt   = count_q - 1'b1;
				end
			end
			MODE_READ_INDEX: begin
				if (SEL_W'(position) >= SEL_W'(count_q)) begin
					status = ST_RANGE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.sel   = SEL_W'(position);
				end
			end
			MODE_READ_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.sel   = '0;
				end
			end
			MODE_READ_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.sel   = SEL_W'(count_q - 1'b1);
				end
			end
			MODE_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				// unused codes change nothing
			end
		endcase
	end

	assign rd_chain[0] = '0;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [DATA_W-1:0] left_d;
			logic [DATA_W-1:0] right_d;

			// front cell takes the new value on a front insert
			if (gi == 0) begin : g_first
				assign left_d = value;
			end else begin : g_mid
				assign left_d = cell_data[gi-1];
			end

			// last cell keeps its data on a left shift, it falls out of the count
			if (gi == DEPTH - 1) begin : g_last
				assign right_d = cell_data[gi];
			end else begin : g_inner
				assign right_d = cell_data[gi+1];
			end

			bol_cell u_cell (
				.clk        (clk),
				.idx        (SEL_W'(gi)),
				.cmd        (cmd),
				.left_data  (left_d),
				.right_data (right_d),
				.hit_in     (hit_chain[gi]),
				.hit_out    (hit_chain[gi+1]),
				.rd_in      (rd_chain[gi]),
				.rd_out     (rd_chain[gi+1]),
				.data       (cell_data[gi])
			);
		end
	endgenerate

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// result beat holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status;
			rdata_q  <= rd_chain[DEPTH];
			ocount_q <= count_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {{(OUT_DATA_W - DATA_W - CNT_W){1'b0}}, ocount_q, rdata_q};

endmodule
